### hw/rtl/sfa_pkg.sv
// ----------------------------------------------------------------------------
// Sprite frame animator package
// Shared widths, register indexes, request codes and control structs.
// ----------------------------------------------------------------------------
package sfa_pkg;

    localparam int FRAME_BITS  = 10;
    localparam int TIME_BITS   = 24;
    localparam int ACC_BITS    = TIME_BITS + 1;
    localparam int COL_BITS    = 9;
    localparam int SIZE_BITS   = 13;
    localparam int LEFT_BITS   = 20;
    localparam int TOP_BITS    = 22;
    localparam int RIGHT_BITS  = 21;
    localparam int BOTTOM_BITS = 23;

    localparam int LEFT_FULL_BITS = COL_BITS + SIZE_BITS;
    localparam int TOP_FULL_BITS  = FRAME_BITS + SIZE_BITS;

    localparam int DIV_STEPS    = FRAME_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

    localparam int S_TDATA_BITS = 40;
    localparam int M_FIELD_BITS = FRAME_BITS + 1 + LEFT_BITS + TOP_BITS
                                  + RIGHT_BITS + BOTTOM_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [CFG_IDX_BITS-1:0] CFG_START_FRAME  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_END_FRAME    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_DELAY  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOOP_ENABLE  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COLUMNS      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 3'd6;

    localparam logic [TIME_BITS-1:0] DELAY_RESET = 24'd1000000;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    typedef struct packed {
        logic load;
        logic accum;
        logic advance;
        logic div_init;
        logic div_step;
        logic mul;
        logic finish;
    } sfa_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_full;
    } sfa_stat_t;

endpackage

### hw/rtl/sfa_ctrl.sv
// ----------------------------------------------------------------------------
// Sprite frame animator controller
// Sequences accumulate, advance, divide, multiply and result hand-off.
// ----------------------------------------------------------------------------
module sfa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sfa_pkg::sfa_stat_t stat,
    input  logic              m_tready,
    output sfa_pkg::sfa_cmd_t cmd
);
    import sfa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCUM,
        S_ADVANCE,
        S_DIV_INIT,
        S_DIVIDE,
        S_MULT,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_ACCUM;
                end
            end
            S_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = S_ADVANCE;
            end
            S_ADVANCE: begin
                cmd.advance = 1'b1;
                state_next  = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                cmd.div_init = 1'b1;
                state_next   = S_DIVIDE;
            end
            S_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_MULT;
                end
            end
            S_MULT: begin
                cmd.mul    = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!stat.out_full || m_tready) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/sfa_datapath.sv
// ----------------------------------------------------------------------------
// Sprite frame animator datapath
// Registers, time accumulator, frame stepping, divider, products, output.
// ----------------------------------------------------------------------------
module sfa_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sfa_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [sfa_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic [sfa_pkg::S_TDATA_BITS-1:0]    s_tdata,
    input  logic                                s_tuser,
    input  sfa_pkg::sfa_cmd_t                   cmd,
    output sfa_pkg::sfa_stat_t                  stat,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sfa_pkg::M_TDATA_BITS-1:0]    m_tdata
);
    import sfa_pkg::*;

    logic [FRAME_BITS-1:0] start_reg, end_reg;
    logic [TIME_BITS-1:0]  delay_reg;
    logic                  loop_reg;
    logic [COL_BITS-1:0]   cols_reg;
    logic [SIZE_BITS-1:0]  fw_reg, fh_reg;

    logic                  type_reg;
    logic [TIME_BITS-1:0]  elapsed_reg;

    logic [ACC_BITS-1:0]   acc_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic                  done_reg;

    logic [FRAME_BITS-1:0]   quot_reg;
    logic [COL_BITS-1:0]     rem_reg;
    logic [COL_BITS-1:0]     dvs_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;

    logic [LEFT_FULL_BITS-1:0] left_reg;
    logic [TOP_FULL_BITS-1:0]  top_reg;

    logic                    out_valid_reg;
    logic [M_TDATA_BITS-1:0] out_data_reg;

    logic                  active;
    logic [ACC_BITS:0]     sum;
    logic [ACC_BITS-1:0]   sat;
    logic [FRAME_BITS:0]   next_frame;
    logic                  out_of_range;
    logic [COL_BITS:0]     trial;
    logic                  trial_ge;
    logic [LEFT_FULL_BITS:0] right_full;
    logic [TOP_FULL_BITS:0]  bottom_full;
    logic [M_FIELD_BITS-1:0] fields;

    assign cfg_ready = 1'b1;

    assign active       = (type_reg == REQ_TICK) && (end_reg > start_reg);
    assign sum          = {1'b0, acc_reg} + {2'b00, elapsed_reg};
    assign sat          = sum[ACC_BITS] ? {ACC_BITS{1'b1}} : sum[ACC_BITS-1:0];
    assign next_frame   = {1'b0, frame_reg} + {{FRAME_BITS{1'b0}}, 1'b1};
    assign out_of_range = (next_frame < {1'b0, start_reg})
                          || (next_frame > {1'b0, end_reg});
    assign trial        = {rem_reg, quot_reg[FRAME_BITS-1]};
    assign trial_ge     = trial >= {1'b0, dvs_reg};
    assign right_full   = {1'b0, left_reg}
                          + {{(LEFT_FULL_BITS - SIZE_BITS + 1){1'b0}}, fw_reg};
    assign bottom_full  = {1'b0, top_reg}
                          + {{(TOP_FULL_BITS - SIZE_BITS + 1){1'b0}}, fh_reg};
    assign fields = {bottom_full[BOTTOM_BITS-1:0], right_full[RIGHT_BITS-1:0],
                     top_reg[TOP_BITS-1:0], left_reg[LEFT_BITS-1:0],
                     done_reg, frame_reg};

    assign stat.div_last = (cnt_reg == DIV_CNT_BITS'(1));
    assign stat.out_full = out_valid_reg;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            end_reg   <= '0;
            delay_reg <= DELAY_RESET;
            loop_reg  <= 1'b1;
            cols_reg  <= COL_BITS'(1);
            fw_reg    <= SIZE_BITS'(2);
            fh_reg    <= SIZE_BITS'(2);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_START_FRAME:  start_reg <= cfg_data[FRAME_BITS-1:0];
                CFG_END_FRAME:    end_reg   <= cfg_data[FRAME_BITS-1:0];
                CFG_FRAME_DELAY:  delay_reg <= cfg_data[TIME_BITS-1:0];
                CFG_LOOP_ENABLE:  loop_reg  <= cfg_data[0];
                CFG_COLUMNS:      cols_reg  <= cfg_data[COL_BITS-1:0];
                CFG_FRAME_WIDTH:  fw_reg    <= cfg_data[SIZE_BITS-1:0];
                CFG_FRAME_HEIGHT: fh_reg    <= cfg_data[SIZE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            frame_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            if (cmd.load && (s_tuser == REQ_SET)) begin
                frame_reg <= s_tdata[TIME_BITS +: FRAME_BITS];
                done_reg  <= 1'b0;
            end
            if (cmd.accum && active) begin
                acc_reg <= sat;
            end
            if (cmd.advance && active && (acc_reg > {1'b0, delay_reg})) begin
                acc_reg <= acc_reg - {1'b0, delay_reg};
                if (!out_of_range) begin
                    frame_reg <= next_frame[FRAME_BITS-1:0];
                end else if (loop_reg) begin
                    frame_reg <= start_reg;
                end else begin
                    frame_reg <= end_reg;
                    done_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            type_reg    <= s_tuser;
            elapsed_reg <= s_tdata[TIME_BITS-1:0];
        end
        if (cmd.div_init) begin
            quot_reg <= frame_reg;
            rem_reg  <= '0;
            dvs_reg  <= (cols_reg == '0) ? COL_BITS'(1) : cols_reg;
        end else if (cmd.div_step) begin
            quot_reg <= {quot_reg[FRAME_BITS-2:0], trial_ge};
            rem_reg  <= trial_ge ? COL_BITS'(trial - {1'b0, dvs_reg})
                                 : trial[COL_BITS-1:0];
        end
        if (cmd.mul) begin
            left_reg <= LEFT_FULL_BITS'(rem_reg) * LEFT_FULL_BITS'(fw_reg);
            top_reg  <= TOP_FULL_BITS'(quot_reg) * TOP_FULL_BITS'(fh_reg);
        end
        if (cmd.finish) begin
            out_data_reg <= {{(M_TDATA_BITS - M_FIELD_BITS){1'b0}}, fields};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.div_init) begin
                cnt_reg <= DIV_CNT_BITS'(DIV_STEPS);
            end else if (cmd.div_step && (cnt_reg != '0)) begin
                cnt_reg <= cnt_reg - DIV_CNT_BITS'(1);
            end
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_finish_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_tvalid)
        else $error("result not presented after finish");

    a_rem_below_dvs: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0) |-> (rem_reg < dvs_reg))
        else $error("partial remainder not below divisor");

    a_set_clears_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && (s_tuser == REQ_SET)) |=> !done_reg)
        else $error("set-frame request left complete flag set");

    a_no_finish_while_dividing: assert property (@(posedge aclk)
        disable iff (!aresetn)
        (cnt_reg != '0) |-> !cmd.finish && !cmd.mul)
        else $error("product or result taken before divide finished");

endmodule

### hw/rtl/sprite_frame_animator_top.sv
// ----------------------------------------------------------------------------
// Sprite frame animator
// Frame sequencing over a sprite sheet with source rectangle output.
// m_tvalid comes from the output register set in the finish state. The next
// request waits for the ten-step restoring divider that splits the frame
// index into column and row, the product and the finish step, which stalls
// while a result is unaccepted. A finished result waits in the output
// register while the next request is taken. Reset (aresetn low, synchronous)
// restores register defaults, clears accumulator, frame, complete flag; no clearing pass.
// ----------------------------------------------------------------------------
module sprite_frame_animator_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sfa_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [sfa_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // elapsed[23:0], frame_number[33:24], zero fill
    input  logic [sfa_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // req_type[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // current_frame[9:0], complete[10], rect_left[30:11], rect_top[52:31],
    // rect_right[73:53], rect_bottom[96:74], zero fill
    output logic [sfa_pkg::M_TDATA_BITS-1:0]  m_tdata
);
    import sfa_pkg::*;

    sfa_cmd_t  cmd;
    sfa_stat_t stat;

    sfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    sfa_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
